// ----- src/mfb_pkg.sv -----
// ----------------------------------------------------------------------------
// mfb_pkg
// Shared constants, codes and control types of the monochrome frame buffer.
// ----------------------------------------------------------------------------
package mfb_pkg;

  localparam int PIXEL_ROWS        = 128;
  localparam int BYTES_PER_ROW     = 16;
  localparam int DISPLAY_ROW_PITCH = 32;

  localparam int STORE_BYTES = PIXEL_ROWS * BYTES_PER_ROW;
  localparam int MEM_AW      = $clog2(STORE_BYTES);
  localparam int ADDR_W      = MEM_AW + 1;
  localparam int CNT_W       = $clog2(BYTES_PER_ROW);

  localparam int ACTION_W = 2;
  localparam int ROW_W    = 7;
  localparam int COL_W    = 7;
  localparam int INDEX_W  = 11;
  localparam int BYTE_W   = 8;
  localparam int CURSOR_W = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [BYTE_W-1:0] CMD_CURSOR_LOW  = 8'h0A;
  localparam logic [BYTE_W-1:0] CMD_CURSOR_HIGH = 8'h0B;
  localparam logic [BYTE_W-1:0] CMD_DATA        = 8'h0C;

  localparam logic [CFG_IDX_W-1:0] CFG_INVERT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE = 1'b1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PLACE = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_FLUSH = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PLACE_RD,
    ST_PLACE_LO,
    ST_PLACE_HI,
    ST_LOAD,
    ST_FLUSH_LO,
    ST_FLUSH_HI,
    ST_FLUSH_DATA
  } state_e;

  typedef struct packed {
    logic capture;
    logic clr_wr;
    logic place_rd;
    logic place_lo;
    logic place_hi;
    logic load_wr;
    logic emit_lo;
    logic emit_hi;
    logic emit_data;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic data_last;
  } dp_status_t;

endpackage

// ----- src/mfb_ctrl.sv -----
// ----------------------------------------------------------------------------
// mfb_ctrl
// Sequencer for clearing, place read-modify-write, load and row flush.
// ----------------------------------------------------------------------------
module mfb_ctrl
  import mfb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [ACTION_W-1:0] action_i,
  input  dp_status_t          status_i,
  output ctrl_cmd_t           cmd_o,
  output logic                busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          unique case (action_e'(action_i))
            ACT_PLACE: state_d = ST_PLACE_RD;
            ACT_LOAD:  state_d = ST_LOAD;
            ACT_FLUSH: state_d = ST_FLUSH_LO;
            ACT_NOP:   state_d = ST_IDLE;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_PLACE_RD: begin
        cmd_o.place_rd = 1'b1;
        state_d        = ST_PLACE_LO;
      end
      ST_PLACE_LO: begin
        cmd_o.place_lo = 1'b1;
        state_d        = ST_PLACE_HI;
      end
      ST_PLACE_HI: begin
        cmd_o.place_hi = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_LOAD: begin
        cmd_o.load_wr = 1'b1;
        state_d       = ST_IDLE;
      end
      ST_FLUSH_LO: begin
        cmd_o.emit_lo = 1'b1;
        state_d       = ST_FLUSH_HI;
      end
      ST_FLUSH_HI: begin
        cmd_o.emit_hi = 1'b1;
        state_d       = ST_FLUSH_DATA;
      end
      ST_FLUSH_DATA: begin
        cmd_o.emit_data = 1'b1;
        if (status_i.data_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  a_flush_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_data && status_i.data_last |=> state_q == ST_IDLE)
    else $error("flush did not return to idle after its last beat");

  a_place_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.place_rd |=> cmd_o.place_lo ##1 cmd_o.place_hi)
    else $error("place read-modify-write sequence broken");

  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_CLEAR |=> state_q != ST_CLEAR)
    else $error("clearing pass reentered after completion");

endmodule

// ----- src/mfb_datapath.sv -----
// ----------------------------------------------------------------------------
// mfb_datapath
// Frame store, item registers, merge logic, flush counter and result beat.
// ----------------------------------------------------------------------------
module mfb_datapath
  import mfb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctrl_cmd_t            cmd_i,
  output dp_status_t           status_o,
  input  logic [ROW_W-1:0]     pixel_row_i,
  input  logic [COL_W-1:0]     pixel_column_i,
  input  logic [INDEX_W-1:0]   byte_index_i,
  input  logic [BYTE_W-1:0]    value_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic                 cfg_data_i,
  output logic                 strobe_o,
  output logic [BYTE_W-1:0]    command_code_o,
  output logic [BYTE_W-1:0]    command_data_o,
  output logic                 last_o
);

  logic [BYTE_W-1:0] mem [STORE_BYTES];

  logic [ROW_W-1:0]   row_q;
  logic [COL_W-1:0]   col_q;
  logic [INDEX_W-1:0] idx_q;
  logic [BYTE_W-1:0]  value_q;
  logic               inv_q, rev_q;
  logic [MEM_AW-1:0]  clr_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [BYTE_W-1:0]  rdata_q;
  logic               rd_ok_q;
  logic               strobe_q, last_q;
  logic [BYTE_W-1:0]  code_q, data_q;

  logic [ADDR_W-1:0]   base, addr0, addr1, raddr, waddr;
  logic [2:0]          bit_ofs;
  logic [BYTE_W-1:0]   keep, bits0, bits1, load_d, load_inv, wdata;
  logic [CURSOR_W-1:0] cursor;
  logic                we, re;
  logic [BYTE_W-1:0]   code_d, data_d;
  logic                last_d;

  assign base    = ADDR_W'(row_q) * ADDR_W'(BYTES_PER_ROW);
  assign addr0   = base + ADDR_W'(col_q[COL_W-1:3]);
  assign addr1   = addr0 + ADDR_W'(1);
  assign bit_ofs = col_q[2:0];
  assign keep    = BYTE_W'((9'd1 << bit_ofs) - 9'd1);
  assign bits0   = BYTE_W'({8'd0, value_q} << bit_ofs);
  assign bits1   = BYTE_W'({8'd0, value_q} >> (4'd8 - {1'b0, bit_ofs}));
  assign cursor  = CURSOR_W'(row_q) * CURSOR_W'(DISPLAY_ROW_PITCH);

  assign load_inv = inv_q ? ~value_q : value_q;
  always_comb begin
    load_d = load_inv;
    if (rev_q) begin
      for (int i = 0; i < BYTE_W; i++) begin
        load_d[i] = load_inv[BYTE_W-1-i];
      end
    end
  end

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = '0;
    raddr = '0;
    wdata = '0;
    priority if (cmd_i.clr_wr) begin
      we    = 1'b1;
      waddr = ADDR_W'(clr_q);
    end else if (cmd_i.place_rd) begin
      re    = 1'b1;
      raddr = addr0;
    end else if (cmd_i.place_lo) begin
      we    = (addr0 < ADDR_W'(STORE_BYTES));
      waddr = addr0;
      wdata = (rdata_q & keep) | (bits0 & ~keep);
      re    = 1'b1;
      raddr = addr1;
    end else if (cmd_i.place_hi) begin
      we    = (bit_ofs != 3'd0) && (addr1 < ADDR_W'(STORE_BYTES));
      waddr = addr1;
      wdata = (rdata_q & ~keep) | (bits1 & keep);
    end else if (cmd_i.load_wr) begin
      we    = (ADDR_W'(idx_q) < ADDR_W'(STORE_BYTES));
      waddr = ADDR_W'(idx_q);
      wdata = load_d;
    end else if (cmd_i.emit_hi) begin
      re    = 1'b1;
      raddr = base;
    end else if (cmd_i.emit_data) begin
      re    = 1'b1;
      raddr = base + ADDR_W'(cnt_q) + ADDR_W'(1);
    end else begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr[MEM_AW-1:0]] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr[MEM_AW-1:0]];
      rd_ok_q <= (raddr < ADDR_W'(STORE_BYTES));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      row_q   <= pixel_row_i;
      col_q   <= pixel_column_i;
      idx_q   <= byte_index_i;
      value_q <= value_i;
    end
  end

  always_comb begin
    code_d = CMD_DATA;
    data_d = rd_ok_q ? rdata_q : '0;
    last_d = cmd_i.emit_data && status_o.data_last;
    if (cmd_i.emit_lo) begin
      code_d = CMD_CURSOR_LOW;
      data_d = cursor[7:0];
    end else if (cmd_i.emit_hi) begin
      code_d = CMD_CURSOR_HIGH;
      data_d = cursor[15:8];
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    data_q <= data_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q    <= 1'b0;
      rev_q    <= 1'b0;
      clr_q    <= '0;
      cnt_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit_lo | cmd_i.emit_hi | cmd_i.emit_data;
      if (cmd_i.clr_wr) begin
        clr_q <= clr_q + MEM_AW'(1);
      end
      if (cmd_i.emit_hi) begin
        cnt_q <= '0;
      end else if (cmd_i.emit_data) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_INVERT:  inv_q <= cfg_data_i;
          CFG_REVERSE: rev_q <= cfg_data_i;
          default:     inv_q <= inv_q;
        endcase
      end
    end
  end

  assign status_o.clr_done  = (clr_q == MEM_AW'(STORE_BYTES - 1));
  assign status_o.data_last = (cnt_q == CNT_W'(BYTES_PER_ROW - 1));

  assign cfg_ready_o    = 1'b1;
  assign strobe_o       = strobe_q;
  assign command_code_o = code_q;
  assign command_data_o = data_q;
  assign last_o         = strobe_q & last_q;

  a_last_is_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q && last_q |-> code_q == CMD_DATA)
    else $error("last beat carries a non-data command");

  a_lo_then_hi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q && code_q == CMD_CURSOR_LOW |=> strobe_q && code_q == CMD_CURSOR_HIGH)
    else $error("cursor high beat does not follow cursor low");

  a_hi_then_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q && code_q == CMD_CURSOR_HIGH |=> strobe_q && code_q == CMD_DATA)
    else $error("data beat does not follow cursor high");

endmodule

// ----- src/mono_framebuffer_blit_and_flush.sv -----
// ----------------------------------------------------------------------------
// mono_framebuffer_blit_and_flush
// One-bit 128x128 frame store with byte place/load and per-row LCD flush.
//
// Items enter through start_i while busy_o is low; action_i selects place,
// load, flush or no operation. Configuration (invert and reverse on load)
// goes through cfg_valid_i/cfg_ready_o; ready is always high.
// Place runs read, merge lower byte, merge spill byte, in that order, as the
// store has a single read and a single write port.
// Load writes the captured byte; a no-op leaves the sequencer idle.
// Flush emits 18 beats on strobe_o, one per cycle:
// cursor low, cursor high, then 16 data beats, last_o on the final one.
// The first beat comes from the beat register, loaded in the cursor-low state that
// follows the accepting edge; each data byte comes from a registered store read
// issued the cycle before. After reset the store is cleared by a pass over all
// 2048 bytes, one byte per cycle, with busy_o high; configuration writes are
// taken meanwhile. The receiver cannot stall: every beat is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module mono_framebuffer_blit_and_flush
  import mfb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [ACTION_W-1:0]  action_i,
  input  logic [ROW_W-1:0]     pixel_row_i,
  input  logic [COL_W-1:0]     pixel_column_i,
  input  logic [INDEX_W-1:0]   byte_index_i,
  input  logic [BYTE_W-1:0]    value_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic                 cfg_data_i,
  output logic                 strobe_o,
  output logic [BYTE_W-1:0]    command_code_o,
  output logic [BYTE_W-1:0]    command_data_o,
  output logic                 last_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  mfb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .action_i (action_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  mfb_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .pixel_row_i    (pixel_row_i),
    .pixel_column_i (pixel_column_i),
    .byte_index_i   (byte_index_i),
    .value_i        (value_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .strobe_o       (strobe_o),
    .command_code_o (command_code_o),
    .command_data_o (command_data_o),
    .last_o         (last_o)
  );

endmodule
